/* rtl/core/idll_pkg.sv */
// Shared types, widths and codes for the indexed doubly linked list.
package idll_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LINK_W      = IDX_W + 1;
  localparam logic [LINK_W-1:0] LINK_NULL = '1;
  localparam int VALUE_W     = 32;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // Response status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Result slot source
  localparam logic [1:0] RS_ZERO  = 2'd0;
  localparam logic [1:0] RS_USED  = 2'd1;
  localparam logic [1:0] RS_PIDX  = 2'd2;
  localparam logic [1:0] RS_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot_index;
  } rsp_word_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       scan;
    logic       ins_a;
    logic       ins_b;
    logic       del_wr;
    logic       res_load;
    logic [1:0] res_status;
    logic [1:0] res_sel;
    logic       out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       full;
    logic       hit;
    logic       scan_end;
    logic       rsp_busy;
  } dp_stat_t;

endpackage

/* rtl/core/idll_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module idll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/idll_datapath.sv */
// Datapath: entry tables, live marks, scan pipeline, tail and response register.
module idll_datapath
  import idll_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  req_word_t req,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  logic [1:0]             req_type;
  logic [VALUE_W-1:0]     req_value;
  logic [LINK_W-1:0]      used_slots;
  logic [LINK_W-1:0]      tail_slot;
  logic [LINK_W-1:0]      scan_cnt;
  logic                   pend;
  logic [IDX_W-1:0]       pidx;
  logic [IDX_W-1:0]       found;
  logic [1:0]             res_status;
  logic [IDX_W-1:0]       res_slot;

  logic [VALUE_W-1:0] value_rdata;
  logic [LINK_W-1:0]  next_rdata;
  logic [LINK_W-1:0]  prev_rdata;
  logic               live_rdata;
  logic               value_we;
  logic               live_we;
  logic [IDX_W-1:0]   live_waddr;
  logic               live_wdata;
  logic               next_we;
  logic [IDX_W-1:0]   next_waddr;
  logic [LINK_W-1:0]  next_wdata;
  logic               prev_we;
  logic [IDX_W-1:0]   prev_waddr;
  logic [LINK_W-1:0]  prev_wdata;
  logic [IDX_W-1:0]   used_idx;
  logic               scan_more;
  logic               hit;
  logic               p_in;
  logic               n_in;
  logic               tail_in;
  logic [IDX_W-1:0]   res_slot_next;

  assign used_idx  = used_slots[IDX_W-1:0];
  assign scan_more = scan_cnt < used_slots;
  assign hit       = pend && live_rdata && (value_rdata == req_value);
  assign p_in      = !prev_rdata[IDX_W];
  assign n_in      = !next_rdata[IDX_W];
  assign tail_in   = !tail_slot[IDX_W];

  // Status back to the controller
  assign stat.req_type = req_type;
  assign stat.full     = used_slots == LINK_W'(TABLE_DEPTH);
  assign stat.hit      = hit;
  assign stat.scan_end = !pend && !scan_more;
  assign stat.rsp_busy = rsp_valid && rsp_stall;

  // Table write ports
  assign value_we = cmd.ins_a;

  // Mark a slot live when handed out, dead when unlinked
  assign live_we    = cmd.ins_a || cmd.del_wr;
  assign live_waddr = cmd.ins_a ? used_idx : found;
  assign live_wdata = cmd.ins_a;

  always_comb begin
    next_we    = 1'b0;
    next_waddr = used_idx;
    next_wdata = LINK_NULL;
    prev_we    = 1'b0;
    prev_waddr = used_idx;
    prev_wdata = tail_slot;
    if (cmd.ins_a) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end else if (cmd.ins_b) begin
      next_we    = tail_in;
      next_waddr = tail_slot[IDX_W-1:0];
      next_wdata = used_slots;
    end else if (cmd.del_wr) begin
      next_we    = p_in;
      next_waddr = prev_rdata[IDX_W-1:0];
      next_wdata = next_rdata;
      prev_we    = n_in;
      prev_waddr = next_rdata[IDX_W-1:0];
      prev_wdata = prev_rdata;
    end
  end

  idll_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (used_idx),
    .wdata (req_value),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (value_rdata)
  );

  // Live marks, read in step with the value RAM
  idll_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (live_rdata)
  );

  idll_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (found),
    .rdata (next_rdata)
  );

  idll_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (found),
    .rdata (prev_rdata)
  );

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type  <= req.req_type;
      req_value <= req.value;
    end
  end

  // Advance the scan one slot a cycle; the compare works on the registered read of the previous slot
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
    end else if (cmd.accept) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_more) begin
        scan_cnt <= scan_cnt + LINK_W'(1);
        pend     <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_more) begin
      pidx <= scan_cnt[IDX_W-1:0];
    end
    if (cmd.scan && hit) begin
      found <= pidx;
    end
  end

  // Hold list bookkeeping: fill count and tail
  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots <= '0;
      tail_slot  <= LINK_NULL;
    end else begin
      if (cmd.ins_b) begin
        tail_slot  <= used_slots;
        used_slots <= used_slots + LINK_W'(1);
      end
      if (cmd.del_wr) begin
        if (tail_slot == {1'b0, found}) begin
          tail_slot <= prev_rdata;
        end
      end
    end
  end

  // Pick the result slot
  always_comb begin
    unique case (cmd.res_sel)
      RS_ZERO:  res_slot_next = '0;
      RS_USED:  res_slot_next = used_idx;
      RS_PIDX:  res_slot_next = pidx;
      RS_FOUND: res_slot_next = found;
      default:  res_slot_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_slot   <= res_slot_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status     <= res_status;
      rsp.slot_index <= (res_status == ST_DONE) ? res_slot : '0;
    end
  end

  // Fill count stays within the table
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_slots <= LINK_W'(TABLE_DEPTH))
    else $error("used slot count beyond table depth");

  // Tail is null or a handed-out slot
  a_tail_used: assert property (@(posedge clk) disable iff (rst)
    tail_slot == LINK_NULL || tail_slot < used_slots)
    else $error("tail beyond used slots");

  // Unlink only touches a handed-out slot
  a_unlink_used: assert property (@(posedge clk) disable iff (rst)
    cmd.del_wr |-> {1'b0, found} < used_slots)
    else $error("unlink beyond used slots");

  // A scan hit only lands on a handed-out slot
  a_hit_used: assert property (@(posedge clk) disable iff (rst)
    cmd.scan && hit |-> {1'b0, pidx} < used_slots)
    else $error("scan hit beyond used slots");

endmodule

/* rtl/core/idll_ctrl.sv */
// Controller: sequences insert, scan and unlink steps and the response hand-off.
module idll_ctrl
  import idll_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_INS_A    = 3'd2;
  localparam logic [2:0] S_INS_B    = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_DEL_RD   = 3'd5;
  localparam logic [2:0] S_DEL_WR   = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = state != S_IDLE;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat.req_type == REQ_INSERT) begin
          if (stat.full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_FULL;
            cmd.res_sel    = RS_ZERO;
            state_next     = S_FINISH;
          end else begin
            state_next = S_INS_A;
          end
        end else if (stat.req_type == REQ_SEARCH || stat.req_type == REQ_DELETE) begin
          state_next = S_SCAN;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          cmd.res_sel    = RS_ZERO;
          state_next     = S_FINISH;
        end
      end
      S_INS_A: begin
        cmd.ins_a  = 1'b1;
        state_next = S_INS_B;
      end
      S_INS_B: begin
        cmd.ins_b      = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_DONE;
        cmd.res_sel    = RS_USED;
        state_next     = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          if (stat.req_type == REQ_DELETE) begin
            state_next = S_DEL_RD;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            cmd.res_sel    = RS_PIDX;
            state_next     = S_FINISH;
          end
        end else if (stat.scan_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          cmd.res_sel    = RS_ZERO;
          state_next     = S_FINISH;
        end
      end
      S_DEL_RD: begin
        // links of the found slot are addressed here; their registered read data is ready in S_DEL_WR
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.del_wr     = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_DONE;
        cmd.res_sel    = RS_FOUND;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.rsp_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A response is loaded only from the finish step
  a_load_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> state == S_FINISH)
    else $error("response loaded outside finish step");

  // Unlink follows its link read directly
  a_del_order: assert property (@(posedge clk) disable iff (rst)
    cmd.del_wr |-> $past(state) == S_DEL_RD)
    else $error("unlink without link read");

endmodule

/* rtl/core/indexed_doubly_linked_list.sv */
// Top level of the indexed doubly linked list: controller plus datapath.
//
//   channel   | handshake              | word
//   ----------+------------------------+-------------------------------
//   request   | req_valid / req_stall  | req (req_type, value)
//   response  | rsp_valid / rsp_stall  | rsp (status, slot_index)
//
// One word at a time. Insert steps through dispatch, two table-write steps and finish;
// an unknown request or full insert goes from dispatch straight to finish. Search and
// delete read one used slot a cycle; delete adds a link read and an unlink step before
// finish. Reset clears the fill count, tail, scan counter, response valid and state;
// live marks sit in RAM with no clearing pass, as only slots below the fill count are read.
// A stalled response holds the block in its finish step until it is taken.
module indexed_doubly_linked_list
  import idll_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  idll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  idll_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
